// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL of the timer wheel.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg: shared constants of the hierarchical timer wheel
// Default geometry, node index encoding and the codes of the request and
// response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

   localparam int NEAR_BITS_DEF   = 8;
   localparam int LEVEL_BITS_DEF  = 6;
   localparam int TIMER_SLOTS_DEF = 64;
   localparam int OUTER_LEVELS    = 4;

   // Node indexes are 7 bits wide; the all-ones code marks an empty link.
   localparam int              NODE_W    = 7;
   localparam logic [NODE_W-1:0] NODE_NONE = 7'h7F;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic KIND_EXPIRED = 1'b0;
   localparam logic KIND_REJECT  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/htw_ram.sv -----
// ----------------------------------------------------------------------------
// htw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel: five-level timing wheel with a fixed node pool
// Timers wait in FIFO buckets of a near wheel and four outer wheels; a tick
// word expires the due near buckets and cascades at most one outer bucket.
// ----------------------------------------------------------------------------
// Usage. A request word is taken at a rising edge where start is high and
// busy is low. req_func selects an add (req_delay, req_handle, req_session)
// or a tick of time. Response words appear on the rsp_ ports for exactly one
// cycle each, marked by rsp_valid; the receiver must take them as they come.
// An add with zero delay, or one that finds the node pool empty, answers in
// the cycle after acceptance with a single word (rsp_kind tells which) and
// busy stays low. An accepted add holds busy while it takes a node off the
// free list and links it into its bucket, and gives no word. A tick holds
// busy while it empties the near bucket of the current tick, advances the
// tick count, cascades an outer bucket when one is due and empties the near
// bucket of the new tick; if that pass gives words and more than one word
// goes out in all, the near bucket is read once more to send the last one.
// Every step goes through the bucket, link and node memories, one read and
// one write per memory per cycle. A tick marks its final word with rsp_last;
// a tick with nothing due gives no word. After reset the block sweeps its
// bucket memory (and the free list of the node pool) one entry per cycle,
// with busy high; after that the tick count is zero and all buckets are empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hierarchical_timer_wheel #(
   parameter int NEAR_BITS   = htw_pkg::NEAR_BITS_DEF,
   parameter int LEVEL_BITS  = htw_pkg::LEVEL_BITS_DEF,
   parameter int TIMER_SLOTS = htw_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic               req_func,
   input  wire logic [31:0]        req_delay,
   input  wire logic [31:0]        req_handle,
   input  wire logic signed [31:0] req_session,
   output      logic               rsp_valid,
   output      logic               rsp_kind,
   output      logic [31:0]        rsp_out_handle,
   output      logic signed [31:0] rsp_out_session,
   output      logic               rsp_last
);

   localparam int NODE_W      = htw_pkg::NODE_W;
   localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
   localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
   localparam int BUCKETS     = NEAR_SLOTS + htw_pkg::OUTER_LEVELS * LEVEL_SLOTS;
   localparam int BKT_W       = $clog2(BUCKETS);
   localparam int NODE_AW     = $clog2(TIMER_SLOTS);
   localparam int BENT_W      = 2 * NODE_W;
   localparam int NDATA_W     = 96;
   localparam logic [63:0] LEVEL_MASK64 = 64'(LEVEL_SLOTS - 1);

   // Sequencer states. The bucket read/clear and node read states are shared
   // by the expiry passes and the cascade; the phase register tells them apart.
   typedef enum logic [12:0] {
      ST_CLEAR     = 13'b0000000000001,
      ST_IDLE      = 13'b0000000000010,
      ST_ADD_LINK  = 13'b0000000000100,
      ST_ADD_FREE  = 13'b0000000001000,
      ST_PLACE_RD  = 13'b0000000010000,
      ST_PLACE_NIL = 13'b0000000100000,
      ST_PLACE_WR  = 13'b0000001000000,
      ST_BKT_RD    = 13'b0000010000000,
      ST_BKT_CLR   = 13'b0000100000000,
      ST_NODE_RD   = 13'b0001000000000,
      ST_EMIT_NODE = 13'b0010000000000,
      ST_CASC_NODE = 13'b0100000000000,
      ST_TICK_ADV  = 13'b1000000000000
   } state_type;

   typedef enum logic [3:0] {
      PH_ADD   = 4'b0001,
      PH_EMIT1 = 4'b0010,
      PH_CASC  = 4'b0100,
      PH_EMIT2 = 4'b1000
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [31:0]          tick_ff, tick_in;
   logic [NODE_W-1:0]    free_head_ff, free_head_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [NODE_W-1:0]    next_ff, next_in;
   logic [NODE_W-1:0]    head_ff, head_in;
   logic [NODE_W-1:0]    tail_ff, tail_in;
   logic [31:0]          expiry_ff, expiry_in;
   logic [31:0]          handle_ff, handle_in;
   logic [31:0]          session_ff, session_in;
   logic [BKT_W-1:0]     bkt_addr_ff, bkt_addr_in;
   logic [BKT_W-1:0]     clr_ff, clr_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [31:0]          pend_handle_ff, pend_handle_in;
   logic [31:0]          pend_session_ff, pend_session_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [31:0]          rsp_handle_ff, rsp_handle_in;
   logic [31:0]          rsp_session_ff, rsp_session_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                 bkt_we;
   logic [BKT_W-1:0]     bkt_waddr, bkt_raddr;
   logic [BENT_W-1:0]    bkt_wdata, bkt_rdata;
   logic                 link_we;
   logic [NODE_AW-1:0]   link_waddr, link_raddr;
   logic [NODE_W-1:0]    link_wdata, link_rdata;
   logic                 node_we;
   logic [NODE_AW-1:0]   node_waddr, node_raddr;
   logic [NDATA_W-1:0]   node_wdata, node_rdata;

   logic                 casc_hit;
   logic [BKT_W-1:0]     casc_bkt;
   logic [31:0]          tick_next;

   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return n < NODE_W'(TIMER_SLOTS);
   endfunction

   // Bucket that a timer expiring at e belongs to, seen from tick t.
   function automatic logic [BKT_W-1:0] place_bucket(input logic [31:0] e,
                                                     input logic [31:0] t);
      logic [63:0] e64;
      logic [63:0] t64;
      logic [63:0] m;
      logic [63:0] slot;
      logic        found;
      int          lvl_sel;
      e64     = {32'd0, e};
      t64     = {32'd0, t};
      found   = 1'b0;
      lvl_sel = 3;
      if ((e >> NEAR_BITS) == (t >> NEAR_BITS)) begin
         return BKT_W'(e[NEAR_BITS-1:0]);
      end
      for (int lvl = 0; lvl < 3; lvl++) begin
         m = (64'd1 << (NEAR_BITS + (lvl + 1) * LEVEL_BITS)) - 64'd1;
         if (!found && ((e64 | m) == (t64 | m))) begin
            lvl_sel = lvl;
            found   = 1'b1;
         end
      end
      slot = (e64 >> (NEAR_BITS + lvl_sel * LEVEL_BITS)) & LEVEL_MASK64;
      return BKT_W'(NEAR_SLOTS + lvl_sel * LEVEL_SLOTS) + BKT_W'(slot);
   endfunction

   // Outer bucket to cascade once the tick count has become t.
   always_comb begin
      logic [63:0] t64;
      logic [63:0] idx;
      logic        stop;
      int          sh;
      t64      = {32'd0, tick_next};
      stop     = 1'b0;
      casc_hit = 1'b0;
      casc_bkt = '0;
      idx      = '0;
      sh       = 0;
      if (tick_next == 32'd0) begin
         casc_hit = 1'b1;
         casc_bkt = BKT_W'(NEAR_SLOTS + 3 * LEVEL_SLOTS);
      end else begin
         for (int lvl = 0; lvl < htw_pkg::OUTER_LEVELS; lvl++) begin
            sh = NEAR_BITS + lvl * LEVEL_BITS;
            if (!stop) begin
               if ((t64 & ((64'd1 << sh) - 64'd1)) == 64'd0) begin
                  idx = (t64 >> sh) & LEVEL_MASK64;
                  if (idx != 64'd0) begin
                     casc_hit = 1'b1;
                     casc_bkt = BKT_W'(NEAR_SLOTS + lvl * LEVEL_SLOTS) + BKT_W'(idx);
                     stop     = 1'b1;
                  end
               end else begin
                  stop = 1'b1;
               end
            end
         end
      end
   end

   assign tick_next = tick_ff + 32'd1;

   // Main sequencer.
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      tick_in         = tick_ff;
      free_head_in    = free_head_ff;
      node_in         = node_ff;
      next_in         = next_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      expiry_in       = expiry_ff;
      handle_in       = handle_ff;
      session_in      = session_ff;
      bkt_addr_in     = bkt_addr_ff;
      clr_in          = clr_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handle_in  = pend_handle_ff;
      pend_session_in = pend_session_ff;
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = htw_pkg::KIND_EXPIRED;
      rsp_handle_in   = rsp_handle_ff;
      rsp_session_in  = rsp_session_ff;
      rsp_last_in     = 1'b0;

      bkt_we     = 1'b0;
      bkt_waddr  = bkt_addr_ff;
      bkt_wdata  = {htw_pkg::NODE_NONE, htw_pkg::NODE_NONE};
      bkt_raddr  = bkt_addr_ff;
      link_we    = 1'b0;
      link_waddr = node_ff[NODE_AW-1:0];
      link_wdata = htw_pkg::NODE_NONE;
      link_raddr = node_ff[NODE_AW-1:0];
      node_we    = 1'b0;
      node_waddr = free_head_ff[NODE_AW-1:0];
      node_wdata = {expiry_ff, handle_ff, session_ff};
      node_raddr = node_ff[NODE_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            if (clr_ff < BKT_W'(TIMER_SLOTS)) begin
               link_we    = 1'b1;
               link_waddr = clr_ff[NODE_AW-1:0];
               link_wdata = (clr_ff + BKT_W'(1) < BKT_W'(TIMER_SLOTS)) ?
                            NODE_W'(clr_ff + BKT_W'(1)) : htw_pkg::NODE_NONE;
            end
            clr_in = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               expiry_in  = tick_ff + req_delay;
               handle_in  = req_handle;
               session_in = req_session;
               if (req_func == htw_pkg::FUNC_ADD) begin
                  if (req_delay == 32'd0 || !node_ok(free_head_ff)) begin
                     // Immediate answer: zero delay expires, a full pool rejects.
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = (req_delay == 32'd0) ? htw_pkg::KIND_EXPIRED
                                                           : htw_pkg::KIND_REJECT;
                     rsp_handle_in  = req_handle;
                     rsp_session_in = req_session;
                     rsp_last_in    = 1'b1;
                  end else begin
                     phase_in = PH_ADD;
                     state_in = ST_ADD_LINK;
                  end
               end else begin
                  phase_in    = PH_EMIT1;
                  bkt_addr_in = BKT_W'(tick_ff[NEAR_BITS-1:0]);
                  state_in    = ST_BKT_RD;
               end
            end
         end
         ST_ADD_LINK: begin
            node_we    = 1'b1;
            link_raddr = free_head_ff[NODE_AW-1:0];
            node_in    = free_head_ff;
            state_in   = ST_ADD_FREE;
         end
         ST_ADD_FREE: begin
            free_head_in = link_rdata;
            state_in     = ST_PLACE_RD;
         end
         ST_PLACE_RD: begin
            bkt_raddr   = place_bucket(expiry_ff, tick_ff);
            bkt_addr_in = bkt_raddr;
            state_in    = ST_PLACE_NIL;
         end
         ST_PLACE_NIL: begin
            link_we  = 1'b1;
            head_in  = bkt_rdata[BENT_W-1:NODE_W];
            tail_in  = bkt_rdata[NODE_W-1:0];
            state_in = ST_PLACE_WR;
         end
         ST_PLACE_WR: begin
            bkt_we = 1'b1;
            if (node_ok(head_ff)) begin
               link_we    = 1'b1;
               link_waddr = tail_ff[NODE_AW-1:0];
               link_wdata = node_ff;
               bkt_wdata  = {head_ff, node_ff};
            end else begin
               bkt_wdata  = {node_ff, node_ff};
            end
            if (phase_ff == PH_CASC) begin
               if (node_ok(next_ff)) begin
                  node_in  = next_ff;
                  state_in = ST_NODE_RD;
               end else begin
                  phase_in    = PH_EMIT2;
                  bkt_addr_in = BKT_W'(tick_ff[NEAR_BITS-1:0]);
                  state_in    = ST_BKT_RD;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BKT_RD: begin
            state_in = ST_BKT_CLR;
         end
         ST_BKT_CLR: begin
            bkt_we  = 1'b1;
            node_in = bkt_rdata[BENT_W-1:NODE_W];
            if (node_ok(bkt_rdata[BENT_W-1:NODE_W])) begin
               state_in = ST_NODE_RD;
            end else if (phase_ff == PH_EMIT1) begin
               state_in = ST_TICK_ADV;
            end else if (phase_ff == PH_CASC) begin
               phase_in    = PH_EMIT2;
               bkt_addr_in = BKT_W'(tick_ff[NEAR_BITS-1:0]);
               state_in    = ST_BKT_RD;
            end else begin
               // End of the tick: the held word goes out as the final one.
               rsp_valid_in   = pend_valid_ff;
               rsp_handle_in  = pend_handle_ff;
               rsp_session_in = pend_session_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         ST_NODE_RD: begin
            state_in = (phase_ff == PH_CASC) ? ST_CASC_NODE : ST_EMIT_NODE;
         end
         ST_EMIT_NODE: begin
            // A word is held back one step so that the final one can be marked.
            rsp_valid_in    = pend_valid_ff;
            rsp_handle_in   = pend_handle_ff;
            rsp_session_in  = pend_session_ff;
            pend_valid_in   = 1'b1;
            pend_handle_in  = node_rdata[63:32];
            pend_session_in = node_rdata[31:0];
            link_we         = 1'b1;
            link_wdata      = free_head_ff;
            free_head_in    = node_ff;
            node_in         = link_rdata;
            if (node_ok(link_rdata)) begin
               state_in = ST_NODE_RD;
            end else if (phase_ff == PH_EMIT1) begin
               state_in = ST_TICK_ADV;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_handle_in  = node_rdata[63:32];
               rsp_session_in = node_rdata[31:0];
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               if (pend_valid_ff) begin
                  // Two words would collide; reread the now empty near bucket to flush the last one.
                  rsp_handle_in  = pend_handle_ff;
                  rsp_session_in = pend_session_ff;
                  rsp_last_in    = 1'b0;
                  pend_valid_in  = 1'b1;
                  bkt_addr_in    = BKT_W'(tick_ff[NEAR_BITS-1:0]);
                  state_in       = ST_BKT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CASC_NODE: begin
            expiry_in = node_rdata[95:64];
            next_in   = link_rdata;
            state_in  = ST_PLACE_RD;
         end
         ST_TICK_ADV: begin
            tick_in = tick_next;
            if (casc_hit) begin
               phase_in    = PH_CASC;
               bkt_addr_in = casc_bkt;
            end else begin
               phase_in    = PH_EMIT2;
               bkt_addr_in = BKT_W'(tick_next[NEAR_BITS-1:0]);
            end
            state_in = ST_BKT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         phase_ff      <= PH_ADD;
         tick_ff       <= '0;
         free_head_ff  <= '0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         free_head_ff  <= free_head_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      node_ff         <= node_in;
      next_ff         <= next_in;
      head_ff         <= head_in;
      tail_ff         <= tail_in;
      expiry_ff       <= expiry_in;
      handle_ff       <= handle_in;
      session_ff      <= session_in;
      bkt_addr_ff     <= bkt_addr_in;
      pend_handle_ff  <= pend_handle_in;
      pend_session_ff <= pend_session_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_handle_ff   <= rsp_handle_in;
      rsp_session_ff  <= rsp_session_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // Bucket list ends: {head, tail} per bucket.
   htw_ram #(.WIDTH(BENT_W), .DEPTH(BUCKETS)) u_bkt_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   // Next-node links, shared by the bucket lists and the free list.
   htw_ram #(.WIDTH(NODE_W), .DEPTH(TIMER_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // Timer payload: {expiry, handle, session}.
   htw_ram #(.WIDTH(NDATA_W), .DEPTH(TIMER_SLOTS)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_handle  = rsp_handle_ff;
   assign rsp_out_session = rsp_session_ff;
   assign rsp_last        = rsp_last_ff;

   `HTW_ASSERT_NOW(a_reject_is_last, clock, reset,
      rsp_valid_ff && rsp_kind_ff == htw_pkg::KIND_REJECT, rsp_last_ff,
      "reject word without last flag")
   `HTW_ASSERT_NOW(a_free_head_code, clock, reset, 1'b1,
      node_ok(free_head_ff) || free_head_ff == htw_pkg::NODE_NONE,
      "free list head holds a bad node index")
   `HTW_ASSERT_NEXT(a_tick_goes_busy, clock, reset,
      start && !busy && req_func == htw_pkg::FUNC_TICK, busy,
      "tick accepted but block not busy")
   `HTW_ASSERT_NOW(a_no_word_in_clear, clock, reset,
      state_ff == ST_CLEAR, !rsp_valid_ff && !pend_valid_ff,
      "response word during clearing sweep")

endmodule

`default_nettype wire
